/* hdl/text_line_int_field_parser_macros.svh */
// ----------------------------------------------------------------------------
// text_line_int_field_parser_macros
// Assertion shorthands used by the checker file of the integer field parser.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_INT_FIELD_PARSER_MACROS_SVH
`define TEXT_LINE_INT_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, off while reset is held
`define TLIFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define TLIFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset cycles
`define TLIFP_ASSERT_NXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tlifp_pkg.sv */
// ----------------------------------------------------------------------------
// tlifp_pkg
// Shared types and constants of the text line integer field parser.
// ----------------------------------------------------------------------------
package tlifp_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENT_BYTE = 2'd1;

  localparam logic [FIELD_W-1:0] DEF_MAX_FIELDS   = 16'd16;
  localparam logic [BYTE_W-1:0]  DEF_COMMENT_BYTE = 8'h23;

  // Queue depths
  localparam int CLS_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Classified input byte
  typedef struct packed {
    logic       sep;
    logic       blank;
    logic       digit;
    logic       minus;
    logic       comment;
    logic       last;
    logic [3:0] dval;
  } class_t;

  // Control part of one result entry (number and/or line end of one byte)
  typedef struct packed {
    logic               has_num;
    logic               has_end;
    logic               neg;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] count;
  } res_ctl_t;

endpackage

/* hdl/text_line_int_field_parser.sv */
// ----------------------------------------------------------------------------
// text_line_int_field_parser
// Splits a byte stream into lines and parses signed decimal integers per line.
//
//   channel  direction  handshake          payload
//   in_      input      in_push / in_full   in_text_byte, in_buffer_last
//   out_     output     out_pop / out_empty number_value, column_index,
//                                           is_line_end, field_count, last_of_run
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_full is low; the parser step (one multiply
// by ten, add and range compare) handles one byte per cycle while the result
// queue has room. One record leaves per cycle while out_pop is high, so a byte
// that closes a line with a pending number gives two records, number first.
// Reset is synchronous: queues and parse state clear, config returns to
// max_fields 16 and comment byte '#'. A stalled output backs up through a
// four-entry result queue and a two-entry byte queue before in_full rises.
// ----------------------------------------------------------------------------
module text_line_int_field_parser #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // byte input
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [tlifp_pkg::BYTE_W-1:0]         in_text_byte,
  input  logic                                 in_buffer_last,
  // results
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [VALUE_WIDTH-1:0]        out_number_value,
  output logic [tlifp_pkg::FIELD_W-1:0]        out_column_index,
  output logic                                 out_is_line_end,
  output logic [tlifp_pkg::FIELD_W-1:0]        out_field_count,
  output logic                                 out_last_of_run,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tlifp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlifp_pkg::FIELD_W-1:0]        cfg_wdata
);
  import tlifp_pkg::*;

  class_t                 cls_head;
  logic                   cls_empty;
  logic                   cls_pop;
  logic [FIELD_W-1:0]     max_fields;
  logic                   res_full;
  logic                   res_push;
  res_ctl_t               res_ctl;
  logic [VALUE_WIDTH-1:0] res_mag;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  tlifp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_text_byte   (in_text_byte),
    .in_buffer_last (in_buffer_last),
    .in_full        (in_full),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .max_fields     (max_fields),
    .cls_pop        (cls_pop),
    .cls_head       (cls_head),
    .cls_empty      (cls_empty)
  );

  tlifp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cls        (cls_head),
    .cls_empty  (cls_empty),
    .cls_pop    (cls_pop),
    .max_fields (max_fields),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_ctl    (res_ctl),
    .res_mag    (res_mag)
  );

  tlifp_out #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_push         (res_push),
    .res_ctl          (res_ctl),
    .res_mag          (res_mag),
    .res_full         (res_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_number_value (out_number_value),
    .out_column_index (out_column_index),
    .out_is_line_end  (out_is_line_end),
    .out_field_count  (out_field_count),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

/* hdl/tlifp_fifo.sv */
// ----------------------------------------------------------------------------
// tlifp_fifo
// Small register queue with count based full/empty; DEPTH a power of two.
// ----------------------------------------------------------------------------
module tlifp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/tlifp_front.sv */
// ----------------------------------------------------------------------------
// tlifp_front
// Config registers, byte classifier and the queue feeding the parser.
// ----------------------------------------------------------------------------
module tlifp_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // byte input
  input  logic                                    in_push,
  input  logic [tlifp_pkg::BYTE_W-1:0]            in_text_byte,
  input  logic                                    in_buffer_last,
  output logic                                    in_full,
  // config writes
  input  logic                                    cfg_valid,
  input  logic [tlifp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tlifp_pkg::FIELD_W-1:0]           cfg_wdata,
  output logic [tlifp_pkg::FIELD_W-1:0]           max_fields,
  // to parser
  input  logic                                    cls_pop,
  output tlifp_pkg::class_t                       cls_head,
  output logic                                    cls_empty
);
  import tlifp_pkg::*;

  logic [FIELD_W-1:0] max_fields_r;
  logic [BYTE_W-1:0]  comment_byte_r;
  class_t             cls;
  logic [$bits(class_t)-1:0] cls_rdata;

  assign max_fields = max_fields_r;

  // Config registers, taken on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r   <= DEF_MAX_FIELDS;
      comment_byte_r <= DEF_COMMENT_BYTE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_FIELDS:   max_fields_r   <= cfg_wdata;
        REG_COMMENT_BYTE: comment_byte_r <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming byte
  always_comb begin
    cls.sep     = (in_text_byte == CHAR_LF) || (in_text_byte == CHAR_CR);
    cls.blank   = (in_text_byte == CHAR_SPACE) || (in_text_byte == CHAR_HT) ||
                  (in_text_byte == CHAR_VT) || (in_text_byte == CHAR_FF);
    cls.digit   = (in_text_byte >= CHAR_ZERO) && (in_text_byte <= CHAR_NINE);
    cls.minus   = (in_text_byte == CHAR_MINUS);
    cls.comment = (in_text_byte == comment_byte_r);
    cls.last    = in_buffer_last;
    cls.dval    = in_text_byte[3:0];
  end

  tlifp_fifo #(
    .WIDTH ($bits(class_t)),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (cls_pop),
    .rdata (cls_rdata),
    .empty (cls_empty)
  );

  assign cls_head = class_t'(cls_rdata);

endmodule

/* hdl/tlifp_back.sv */
// ----------------------------------------------------------------------------
// tlifp_back
// Line and token state machine: one classified byte per cycle while the result
// queue has room; at most one entry (number, line end, or both) per byte.
// ----------------------------------------------------------------------------
module tlifp_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlifp_pkg::class_t             cls,
  input  logic                          cls_empty,
  output logic                          cls_pop,
  input  logic [tlifp_pkg::FIELD_W-1:0] max_fields,
  input  logic                          res_full,
  output logic                          res_push,
  output tlifp_pkg::res_ctl_t           res_ctl,
  output logic [VALUE_WIDTH-1:0]        res_mag
);
  import tlifp_pkg::*;

  localparam int PROD_W = VALUE_WIDTH + 4;

  typedef enum logic [1:0] {LP_START, LP_LINE, LP_AFTER} line_phase_t;
  typedef enum logic [1:0] {TP_BETWEEN, TP_SIGN, TP_DIGITS, TP_STOPPED} token_phase_t;

  line_phase_t            lp_r,  lp_nxt;
  token_phase_t           tp_r,  tp_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [FIELD_W-1:0]     fl_r,  fl_nxt;

  logic              step;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] limit;
  logic              ovf;

  assign step     = !cls_empty && !res_full;
  assign cls_pop  = step;
  assign res_push = step && (res_ctl.has_num || res_ctl.has_end);

  // mag * 10 + digit against the signed range limit
  always_comb begin
    prod  = (PROD_W'(mag_r) << 3) + (PROD_W'(mag_r) << 1) + PROD_W'(cls.dval);
    limit = (PROD_W'(1) << (VALUE_WIDTH - 1)) - PROD_W'(!neg_r);
    ovf   = prod > limit;
  end

  // Next state and result entry for the head byte
  always_comb begin
    lp_nxt  = lp_r;
    tp_nxt  = tp_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    fl_nxt  = fl_r;
    res_ctl = '0;
    res_mag = '0;

    if (cls.sep) begin
      if (lp_r == LP_START) begin
        // separator at buffer start: empty line
        fl_nxt          = '0;
        tp_nxt          = TP_BETWEEN;
        neg_nxt         = 1'b0;
        mag_nxt         = '0;
        res_ctl.has_end = 1'b1;
        res_ctl.count   = '0;
        lp_nxt          = LP_AFTER;
      end else if (lp_r == LP_LINE) begin
        if (tp_r == TP_DIGITS) begin
          res_ctl.has_num = 1'b1;
          res_ctl.neg     = neg_r;
          res_ctl.column  = fl_r;
          res_mag         = mag_r;
          fl_nxt          = fl_r + FIELD_W'(1);
        end
        res_ctl.has_end = 1'b1;
        res_ctl.count   = fl_nxt;
        tp_nxt          = TP_BETWEEN;
        lp_nxt          = LP_AFTER;
      end
    end else begin
      if (lp_r != LP_LINE) begin
        lp_nxt  = LP_LINE;
        tp_nxt  = TP_BETWEEN;
        neg_nxt = 1'b0;
        mag_nxt = '0;
        fl_nxt  = '0;
      end
      if (cls.comment) begin
        // comment: flush a pending number, ignore the rest of the line
        if (tp_nxt == TP_DIGITS) begin
          res_ctl.has_num = 1'b1;
          res_ctl.neg     = neg_nxt;
          res_ctl.column  = fl_nxt;
          res_mag         = mag_nxt;
          fl_nxt          = fl_nxt + FIELD_W'(1);
        end
        tp_nxt = TP_STOPPED;
      end else begin
        case (tp_nxt)
          TP_BETWEEN: begin
            if (!cls.blank) begin
              if (fl_nxt >= max_fields) begin
                tp_nxt = TP_STOPPED;
              end else if (cls.minus) begin
                tp_nxt  = TP_SIGN;
                neg_nxt = 1'b1;
                mag_nxt = '0;
              end else if (cls.digit) begin
                tp_nxt  = TP_DIGITS;
                neg_nxt = 1'b0;
                mag_nxt = VALUE_WIDTH'(cls.dval);
              end else begin
                tp_nxt = TP_STOPPED;
              end
            end
          end
          TP_SIGN: begin
            if (cls.digit) begin
              if (ovf) begin
                tp_nxt = TP_STOPPED;
              end else begin
                tp_nxt  = TP_DIGITS;
                mag_nxt = prod[VALUE_WIDTH-1:0];
              end
            end else begin
              tp_nxt = TP_STOPPED;
            end
          end
          TP_DIGITS: begin
            if (cls.digit) begin
              if (ovf) begin
                tp_nxt = TP_STOPPED;
              end else begin
                mag_nxt = prod[VALUE_WIDTH-1:0];
              end
            end else begin
              // number ends here; this byte may start the next one
              res_ctl.has_num = 1'b1;
              res_ctl.neg     = neg_r;
              res_ctl.column  = fl_r;
              res_mag         = mag_r;
              fl_nxt          = fl_r + FIELD_W'(1);
              tp_nxt          = TP_BETWEEN;
              if (!cls.blank) begin
                if (fl_nxt >= max_fields) begin
                  tp_nxt = TP_STOPPED;
                end else if (cls.minus) begin
                  tp_nxt  = TP_SIGN;
                  neg_nxt = 1'b1;
                  mag_nxt = '0;
                end else begin
                  tp_nxt = TP_STOPPED;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    // final byte of the buffer: close the open line, back to buffer start
    if (cls.last) begin
      if (lp_nxt == LP_LINE) begin
        if (tp_nxt == TP_DIGITS) begin
          res_ctl.has_num = 1'b1;
          res_ctl.neg     = neg_nxt;
          res_ctl.column  = fl_nxt;
          res_mag         = mag_nxt;
          fl_nxt          = fl_nxt + FIELD_W'(1);
        end
        res_ctl.has_end = 1'b1;
        res_ctl.count   = fl_nxt;
      end
      lp_nxt  = LP_START;
      tp_nxt  = TP_BETWEEN;
      neg_nxt = 1'b0;
      mag_nxt = '0;
      fl_nxt  = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r  <= LP_START;
      tp_r  <= TP_BETWEEN;
      neg_r <= 1'b0;
      mag_r <= '0;
      fl_r  <= '0;
    end else if (step) begin
      lp_r  <= lp_nxt;
      tp_r  <= tp_nxt;
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      fl_r  <= fl_nxt;
    end
  end

endmodule

/* hdl/tlifp_out.sv */
// ----------------------------------------------------------------------------
// tlifp_out
// Result queue; splits an entry holding a number and a line end into two
// records, and applies the sign to the stored magnitude.
// ----------------------------------------------------------------------------
module tlifp_out #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 res_push,
  input  tlifp_pkg::res_ctl_t                  res_ctl,
  input  logic [VALUE_WIDTH-1:0]               res_mag,
  output logic                                 res_full,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [VALUE_WIDTH-1:0]        out_number_value,
  output logic [tlifp_pkg::FIELD_W-1:0]        out_column_index,
  output logic                                 out_is_line_end,
  output logic [tlifp_pkg::FIELD_W-1:0]        out_field_count,
  output logic                                 out_last_of_run
);
  import tlifp_pkg::*;

  localparam int ENT_W = $bits(res_ctl_t) + VALUE_WIDTH;

  logic [ENT_W-1:0]       head;
  res_ctl_t               head_ctl;
  logic [VALUE_WIDTH-1:0] head_mag;
  logic                   half_r;
  logic                   both;
  logic                   show_num;
  logic                   xfer;
  logic                   q_pop;

  tlifp_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_ctl, res_mag}),
    .full  (res_full),
    .pop   (q_pop),
    .rdata (head),
    .empty (out_empty)
  );

  assign head_ctl = res_ctl_t'(head[ENT_W-1:VALUE_WIDTH]);
  assign head_mag = head[VALUE_WIDTH-1:0];

  // Two-record entries go out number first, then line end
  assign both     = head_ctl.has_num && head_ctl.has_end;
  assign show_num = head_ctl.has_num && !(head_ctl.has_end && half_r);
  assign xfer     = out_pop && !out_empty;
  assign q_pop    = xfer && !(both && !half_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else if (xfer) begin
      half_r <= both && !half_r;
    end
  end

  // Record fields
  always_comb begin
    out_number_value = '0;
    out_column_index = '0;
    out_field_count  = '0;
    out_is_line_end  = !show_num;
    out_last_of_run  = !(both && !half_r);
    if (show_num) begin
      out_number_value = head_ctl.neg ? -head_mag : head_mag;
      out_column_index = head_ctl.column;
    end else begin
      out_field_count  = head_ctl.count;
    end
  end

endmodule

/* hdl/tlifp_checker.sv */
// ----------------------------------------------------------------------------
// tlifp_checker
// Port-level checks of the integer field parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_line_int_field_parser_macros.svh"

module tlifp_checker #(
  parameter int VALUE_WIDTH = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic signed [VALUE_WIDTH-1:0]   out_number_value,
  input logic [tlifp_pkg::FIELD_W-1:0]   out_column_index,
  input logic                            out_is_line_end,
  input logic [tlifp_pkg::FIELD_W-1:0]   out_field_count,
  input logic                            out_last_of_run
);

  // A line end is always the final record of its byte
  `TLIFP_ASSERT_IMP(a_end_is_last, !out_empty && out_is_line_end, out_last_of_run, "line end not last of run")

  // Unused fields of a record read as zero
  `TLIFP_ASSERT_IMP(a_zero_fields, !out_empty, out_is_line_end ? (out_number_value == 0 && out_column_index == 0) : (out_field_count == 0), "unused record field not zero")

  // A number that is not last of its run is followed by its line end
  `TLIFP_ASSERT_NXT(a_num_then_end, !out_empty && out_pop && !out_is_line_end && !out_last_of_run, !out_empty && out_is_line_end, "number not followed by line end")

  // A waiting record holds while not taken
  `TLIFP_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_number_value) && $stable(out_is_line_end) && $stable(out_field_count), "waiting record changed")

  // Reset leaves both queues empty
  `TLIFP_ASSERT_NXT_ALWAYS(a_reset_empty, !rst_n, out_empty && !in_full, "queues not empty after reset")

endmodule

bind text_line_int_field_parser tlifp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tlifp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_number_value (out_number_value),
  .out_column_index (out_column_index),
  .out_is_line_end  (out_is_line_end),
  .out_field_count  (out_field_count),
  .out_last_of_run  (out_last_of_run)
);
